// ----- src/cp2u8_pkg.sv -----
// Package: encoding codes, codepage tables and queue entry type for the transcoder
`timescale 1ns / 1ps
`default_nettype none
package cp2u8_pkg;

  localparam logic [1:0] ENC_UTF8    = 2'd0;
  localparam logic [1:0] ENC_WIN1251 = 2'd1;
  localparam logic [1:0] ENC_WIN1252 = 2'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Windows-1251 0x80..0xFF
  localparam logic [15:0] CP1251_UPPER [128] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0020, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
    16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
    16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
    16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
    16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
    16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
  };

  // Windows-1252 0x80..0x9F; holes are spaces
  localparam logic [15:0] CP1252_LOW_UPPER [32] = '{
    16'h20AC, 16'h0020, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0020, 16'h017D, 16'h0020,
    16'h0020, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0020, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;  // 1..3
    logic       eot;
  } q_entry_t;

endpackage
`default_nettype wire

// ----- src/cp2u8_if.sv -----
// Interfaces: source byte channel and UTF-8 result channel
`timescale 1ns / 1ps
`default_nettype none
interface cp2u8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface cp2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output run_last, output text_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface
`default_nettype wire

// ----- src/codepage_to_utf8_transcoder.sv -----
// Top level: codepage to UTF-8 transcoder
`timescale 1ns / 1ps
`default_nettype none
// Takes one source text byte per transaction and emits its UTF-8 form, one byte
// per result transaction, with run_last on the final byte of each character and
// text_end on the final byte of a character whose input had end_of_text set.
// cfg_wdata selects the source encoding (0 passthrough, 1 Windows-1251,
// 2 Windows-1252 with Latin-1 upper half, 3 acts as passthrough); write it only
// while the block is idle. An input byte occupies the result channel for as
// many transactions as its UTF-8 length, 1 to 3, since the back-end serialiser
// puts out one byte per cycle while the result channel is ready; the input side
// keeps taking bytes into a four-entry queue meanwhile until that queue is full.
module codepage_to_utf8_transcoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  cp2u8_in_if.sink         in_ch,
  cp2u8_out_if.source      out_ch
);
  import cp2u8_pkg::*;

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_nonempty;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  cp2u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  cp2u8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  cp2u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- src/cp2u8_front.sv -----
// Front end: encoding register, codepage lookup and UTF-8 byte formation
`timescale 1ns / 1ps
`default_nettype none
module cp2u8_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  cp2u8_in_if.sink               in_ch,
  input  wire logic              q_full,
  output logic                   q_push,
  output cp2u8_pkg::q_entry_t    q_wdata
);
  import cp2u8_pkg::*;

  logic [1:0]  enc_r;
  logic [1:0]  enc_nxt;
  logic [15:0] code;
  logic        mapped;

  always_comb begin
    enc_nxt = enc_r;
    if (cfg_we) begin
      enc_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= ENC_UTF8;
    end else begin
      enc_r <= enc_nxt;
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // code point of the byte; ASCII always maps to itself
  always_comb begin
    code   = {8'h00, in_ch.in_byte};
    mapped = 1'b0;
    unique case (enc_r)
      ENC_WIN1251: begin
        mapped = 1'b1;
        if (in_ch.in_byte[7]) begin
          code = CP1251_UPPER[in_ch.in_byte[6:0]];
        end
      end
      ENC_WIN1252: begin
        mapped = 1'b1;
        if (in_ch.in_byte[7:5] == 3'b100) begin
          code = CP1252_LOW_UPPER[in_ch.in_byte[4:0]];
        end
      end
      default: mapped = 1'b0;  // passthrough, unused code included
    endcase
  end

  always_comb begin
    q_wdata.eot = in_ch.end_of_text;
    q_wdata.b1  = {2'b10, code[11:6]};
    q_wdata.b2  = {2'b10, code[5:0]};
    if (!mapped || code[15:7] == 9'd0) begin
      q_wdata.b0     = code[7:0];
      q_wdata.nbytes = 2'd1;
    end else if (code[15:11] == 5'd0) begin
      q_wdata.b0     = {3'b110, code[10:6]};
      q_wdata.b1     = {2'b10, code[5:0]};
      q_wdata.nbytes = 2'd2;
    end else begin
      q_wdata.b0     = {4'b1110, code[15:12]};
      q_wdata.nbytes = 2'd3;
    end
  end

endmodule
`default_nettype wire

// ----- src/cp2u8_fifo.sv -----
// Short queue of formed characters between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module cp2u8_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire cp2u8_pkg::q_entry_t wdata,
  input  wire logic                pop,
  output cp2u8_pkg::q_entry_t      rdata,
  output logic                     full,
  output logic                     nonempty
);
  import cp2u8_pkg::*;

  q_entry_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  assign full     = (count_r == QDEPTH[QAW:0]);
  assign nonempty = (count_r != '0);
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- src/cp2u8_back.sv -----
// Back end: serialises one queued character into UTF-8 bytes on the result channel
`timescale 1ns / 1ps
`default_nettype none
module cp2u8_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_nonempty,
  input  wire cp2u8_pkg::q_entry_t q_rdata,
  output logic                     q_pop,
  cp2u8_out_if.source              out_ch
);
  import cp2u8_pkg::*;

  q_entry_t   cur_r, cur_nxt;
  logic       have_r, have_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;
  logic       oend_r, oend_nxt;
  logic       out_free;
  logic       emit;
  logic       last;
  logic [7:0] sel_byte;

  assign out_free = !ovalid_r || out_ch.ready;
  assign emit     = have_r && out_free;
  assign last     = (idx_r == cur_r.nbytes - 2'd1);
  // refill on the cycle the final byte leaves so single-byte characters stream
  assign q_pop    = q_nonempty && (!have_r || (emit && last));

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = cur_r.b0;
      2'd1:    sel_byte = cur_r.b1;
      default: sel_byte = cur_r.b2;
    endcase
  end

  always_comb begin
    cur_nxt    = cur_r;
    have_nxt   = have_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    oend_nxt   = oend_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = sel_byte;
      olast_nxt  = last;
      oend_nxt   = last && cur_r.eot;
      idx_nxt    = idx_r + 2'd1;
      if (last) begin
        have_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_nxt  = q_rdata;
      have_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      ovalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      have_r   <= have_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_byte = obyte_r;
  assign out_ch.run_last = olast_r;
  assign out_ch.text_end = oend_r;

endmodule
`default_nettype wire
